/* sv/tmgr_pkg.sv */
// Shared types, constants and colour palette of the text-mode glyph renderer.
`default_nettype none
package tmgr_pkg;

  localparam int GLYPH_ROWS = 16;
  localparam int STRIDE_W   = 4;
  localparam int CHAR_W     = 8;
  localparam int ADDR_W     = CHAR_W + STRIDE_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CNT_W      = $clog2(GLYPH_ROWS + 1);
  localparam int CURSOR_LINES = 4;

  localparam logic [1:0] REQ_FONT   = 2'd0;
  localparam logic [1:0] REQ_CELL   = 2'd1;
  localparam logic [1:0] REQ_CURSOR = 2'd2;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [7:0] RST_COLUMNS = 8'd80;
  localparam logic [7:0] RST_ROWS    = 8'd25;

  localparam logic [3:0] PAL_WHITE = 4'd15;
  localparam logic [3:0] PAL_BLACK = 4'd0;

  localparam logic [23:0] PALETTE [16] = '{
    24'h000000, 24'h0000ff, 24'h00ff00, 24'h00ffff,
    24'hff0000, 24'hff00ff, 24'hff4040, 24'hd3d3d3,
    24'h404040, 24'h87cefa, 24'h9aff9a, 24'he0ffff,
    24'hffc1c1, 24'h00ff00, 24'hffff00, 24'hffffff
  };

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         character_code;
    logic [7:0]         attribute;
    logic signed [15:0] cell_column;
    logic signed [15:0] cell_row;
    logic [3:0]         glyph_row;
    logic [7:0]         glyph_byte;
  } item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  row_mask;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic        paint_background;
    logic        last;
  } result_t;

  typedef struct packed {
    logic                capture;
    logic                font_wr;
    logic                rd_en;
    logic [STRIDE_W-1:0] rd_row;
    logic                load;
    logic [STRIDE_W-1:0] load_row;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cursor_ok;
  } sts_t;

endpackage
`default_nettype wire

/* sv/tmgr_in_if.sv */
// Request channel interface of the glyph renderer.
`default_nettype none
interface tmgr_in_if;
  import tmgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         character_code;
  logic [7:0]         attribute;
  logic signed [15:0] cell_column;
  logic signed [15:0] cell_row;
  logic [3:0]         glyph_row;
  logic [7:0]         glyph_byte;

  modport source (
    output valid, req_type, character_code, attribute, cell_column, cell_row,
           glyph_row, glyph_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, character_code, attribute, cell_column, cell_row,
           glyph_row, glyph_byte,
    output ready
  );
endinterface
`default_nettype wire

/* sv/tmgr_out_if.sv */
// Scanline result channel interface of the glyph renderer.
`default_nettype none
interface tmgr_out_if;
  import tmgr_pkg::*;

  logic        valid;
  logic        ready;
  logic [10:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  row_mask;
  logic [23:0] fg_color;
  logic [23:0] bg_color;
  logic        paint_background;
  logic        last;

  modport source (
    output valid, pixel_x, pixel_y, row_mask, fg_color, bg_color, paint_background, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, row_mask, fg_color, bg_color, paint_background, last,
    output ready
  );
endinterface
`default_nettype wire

/* sv/tmgr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tmgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/tmgr_ctrl.sv */
// Controller: request acceptance and scanline read/load sequencing.
`default_nettype none
module tmgr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_req_type,
  output logic                in_ready,
  input  wire tmgr_pkg::sts_t sts,
  output tmgr_pkg::cmd_t      cmd
);
  import tmgr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                state_r, state_nxt;
  logic [CNT_W-1:0]    issue_cnt_r, issue_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [STRIDE_W-1:0] pend_row_r, pend_row_nxt;
  logic                accept;
  logic                issue;
  logic                load;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = pend_r && sts.out_free;
  assign issue    = (state_r == S_RUN) && (issue_cnt_r != CNT_W'(GLYPH_ROWS))
                    && (!pend_r || load);

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt     = pend_r;
    pend_row_nxt = pend_row_r;
    cmd.rd_row   = issue_cnt_r[STRIDE_W-1:0];
    cmd.load_row = pend_row_r;
    cmd.load     = load;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_FONT: cmd.font_wr = 1'b1;
            REQ_CELL: begin
              cmd.capture   = 1'b1;
              issue_cnt_nxt = '0;
              state_nxt     = S_RUN;
            end
            REQ_CURSOR: begin
              if (sts.cursor_ok) begin
                cmd.capture   = 1'b1;
                issue_cnt_nxt = '0;
                state_nxt     = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (issue) begin
          cmd.rd_en     = 1'b1;
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
          pend_nxt      = 1'b1;
          pend_row_nxt  = issue_cnt_r[STRIDE_W-1:0];
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load && pend_row_r == STRIDE_W'(GLYPH_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_cnt_r <= '0;
      pend_r      <= 1'b0;
      pend_row_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      pend_r      <= pend_nxt;
      pend_row_r  <= pend_row_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/tmgr_dp.sv */
// Datapath: console registers, glyph store, request capture and result register.
`default_nettype none
module tmgr_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tmgr_pkg::item_t  item,
  input  wire tmgr_pkg::cmd_t   cmd,
  output tmgr_pkg::sts_t        sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tmgr_pkg::result_t     res,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tmgr_pkg::*;

  logic [7:0]        cols_r, rows_r;
  logic              cfg_wr;
  logic [CHAR_W-1:0] char_r;
  logic [10:0]       x_r;
  logic [11:0]       base_y_r;
  logic [23:0]       fg_r, bg_r;
  logic              paint_r;
  logic              cursor_r;
  logic [7:0]        ram_rdata;
  logic [7:0]        mask;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= RST_COLUMNS;
      rows_r <= RST_ROWS;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COLUMNS: cols_r <= pwdata[7:0];
        REG_ROWS:    rows_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      prdata = (paddr[2] == REG_COLUMNS) ? {24'd0, cols_r} : {24'd0, rows_r};
    end
  end

  assign sts.cursor_ok = !item.cell_column[15] && (item.cell_column[14:0] < {7'd0, cols_r})
                         && !item.cell_row[15] && (item.cell_row[14:0] < {7'd0, rows_r});
  assign sts.out_free  = !out_valid_r || out_ready;

  tmgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.font_wr),
    .waddr ({item.character_code, item.glyph_row}),
    .wdata (item.glyph_byte),
    .re    (cmd.rd_en && !cursor_r),
    .raddr ({char_r, cmd.rd_row}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_r   <= item.character_code;
      x_r      <= {item.cell_column[7:0], 3'b000};
      base_y_r <= 12'(item.cell_row * GLYPH_ROWS);
      cursor_r <= (item.req_type == REQ_CURSOR);
      if (item.req_type == REQ_CURSOR) begin
        fg_r    <= PALETTE[PAL_WHITE];
        bg_r    <= PALETTE[PAL_BLACK];
        paint_r <= 1'b0;
      end else begin
        fg_r    <= PALETTE[item.attribute[3:0]];
        bg_r    <= PALETTE[{1'b0, item.attribute[6:4]}];
        paint_r <= 1'b1;
      end
    end
  end

  always_comb begin
    if (cursor_r) begin
      mask = (cmd.load_row >= STRIDE_W'(GLYPH_ROWS - CURSOR_LINES)) ? 8'hff : 8'h00;
    end else begin
      mask = ram_rdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r.pixel_x          <= x_r;
      res_r.pixel_y          <= base_y_r + 12'(cmd.load_row);
      res_r.row_mask         <= mask;
      res_r.fg_color         <= fg_r;
      res_r.bg_color         <= bg_r;
      res_r.paint_background <= paint_r;
      res_r.last             <= (cmd.load_row == STRIDE_W'(GLYPH_ROWS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

/* sv/text_mode_glyph_renderer.sv */
// Top level of the text-mode glyph renderer.
// Font-write requests store one glyph row byte into a 4096 x 8 glyph store
// (address character_code * 16 + glyph_row) and give no result. A cell
// request, or a cursor request inside the console bounds, gives 16 scanline
// results. Once such a request is accepted, for a cell request one glyph row
// is read from the store's single read port each cycle while the output is
// not stalled, and each row read is registered as a scanline result. Glyph
// rows must be written before they are drawn. A cursor request outside the
// bounds and an unused request code give nothing. Console columns sit at
// byte address 0 and rows at 4 on the register port.
`default_nettype none
module text_mode_glyph_renderer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tmgr_in_if.sink          in_ch,
  tmgr_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import tmgr_pkg::*;

  item_t   item;
  cmd_t    cmd;
  sts_t    sts;
  result_t res;
  logic    in_ready;
  logic    out_valid;

  assign item.req_type       = in_ch.req_type;
  assign item.character_code = in_ch.character_code;
  assign item.attribute      = in_ch.attribute;
  assign item.cell_column    = in_ch.cell_column;
  assign item.cell_row       = in_ch.cell_row;
  assign item.glyph_row      = in_ch.glyph_row;
  assign item.glyph_byte     = in_ch.glyph_byte;
  assign in_ch.ready         = in_ready;

  tmgr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tmgr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.pixel_x          = res.pixel_x;
  assign out_ch.pixel_y          = res.pixel_y;
  assign out_ch.row_mask         = res.row_mask;
  assign out_ch.fg_color         = res.fg_color;
  assign out_ch.bg_color         = res.bg_color;
  assign out_ch.paint_background = res.paint_background;
  assign out_ch.last             = res.last;

endmodule
`default_nettype wire

/* tb/tb_text_mode_glyph_renderer.sv */
// Self-checking testbench for the text-mode glyph renderer: font, cell and cursor requests.
`timescale 1ns / 1ps
module tb_text_mode_glyph_renderer;
  import tmgr_pkg::*;

  localparam logic [23:0] COLOUR_TABLE [16] = '{
    24'h000000, 24'h0000ff, 24'h00ff00, 24'h00ffff,
    24'hff0000, 24'hff00ff, 24'hff4040, 24'hd3d3d3,
    24'h404040, 24'h87cefa, 24'h9aff9a, 24'he0ffff,
    24'hffc1c1, 24'h00ff00, 24'hffff00, 24'hffffff
  };
  localparam int ITEMS_PER_PHASE = 27;
  localparam int SETTLE_CYCLES   = 24;

  class scanline_scoreboard;
    logic [7:0] glyph_mirror [STORE_DEPTH];
    logic [7:0] columns_limit;
    logic [7:0] rows_limit;
    result_t    pending_scanlines [$];
    int         errors;
    int         checked;
    int         cursors_shown;

    function new();
      columns_limit = RST_COLUMNS;
      rows_limit    = RST_ROWS;
      errors        = 0;
      checked       = 0;
      cursors_shown = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == REG_COLUMNS) columns_limit = value;
      else rows_limit = value;
    endfunction

    function void queue_glyph(logic [15:0] col, logic [15:0] row, logic [7:0] rows [GLYPH_ROWS],
                              logic [23:0] fg, logic [23:0] bg, logic paint);
      result_t r;
      for (int s = 0; s < GLYPH_ROWS; s++) begin
        r.pixel_x          = {col[7:0], 3'b000};
        r.pixel_y          = {row[7:0], 4'b0000} + 12'(s);
        r.row_mask         = rows[s];
        r.fg_color         = fg;
        r.bg_color         = bg;
        r.paint_background = paint;
        r.last             = (s == GLYPH_ROWS - 1);
        pending_scanlines.push_back(r);
      end
    endfunction

    function void note_request(item_t rq);
      logic [7:0] rows [GLYPH_ROWS];
      int c;
      int r;
      c = $signed(rq.cell_column);
      r = $signed(rq.cell_row);
      case (rq.req_type)
        REQ_FONT: begin
          glyph_mirror[{rq.character_code, rq.glyph_row}] = rq.glyph_byte;
        end
        REQ_CELL: begin
          for (int s = 0; s < GLYPH_ROWS; s++)
            rows[s] = glyph_mirror[{rq.character_code, 4'(s)}];
          queue_glyph(rq.cell_column, rq.cell_row, rows, COLOUR_TABLE[rq.attribute[3:0]],
                      COLOUR_TABLE[{1'b0, rq.attribute[6:4]}], 1'b1);
        end
        REQ_CURSOR: begin
          if (c >= 0 && c < int'(columns_limit) && r >= 0 && r < int'(rows_limit)) begin
            for (int s = 0; s < GLYPH_ROWS; s++)
              rows[s] = (s >= GLYPH_ROWS - CURSOR_LINES) ? 8'hff : 8'h00;
            queue_glyph(rq.cell_column, rq.cell_row, rows, COLOUR_TABLE[PAL_WHITE],
                        COLOUR_TABLE[PAL_BLACK], 1'b0);
            cursors_shown++;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        errors++;
        if (errors < 60)
          $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_scanline(result_t got);
      result_t want;
      if (pending_scanlines.size() == 0) begin
        errors++;
        if (errors < 60)
          $display("%0t: unexpected scanline, expected none, got %h", $time, got);
        return;
      end
      want = pending_scanlines.pop_front();
      checked++;
      compare_field("pixel_x", 24'(want.pixel_x), 24'(got.pixel_x));
      compare_field("pixel_y", 24'(want.pixel_y), 24'(got.pixel_y));
      compare_field("row_mask", 24'(want.row_mask), 24'(got.row_mask));
      compare_field("fg_color", want.fg_color, got.fg_color);
      compare_field("bg_color", want.bg_color, got.bg_color);
      compare_field("paint_background", 24'(want.paint_background), 24'(got.paint_background));
      compare_field("last", 24'(want.last), 24'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tmgr_in_if  in_ch ();
  tmgr_out_if out_ch ();

  text_mode_glyph_renderer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scanline_scoreboard sb;
  logic [15:0] rows_written [256];
  int send_idle_pct;
  int recv_idle_pct;
  int n_font;
  int n_cell;
  int n_cursor;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** text_mode_glyph_renderer: FAILED **");
    $finish;
  end

  initial begin
    result_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.pixel_x          = out_ch.pixel_x;
        got.pixel_y          = out_ch.pixel_y;
        got.row_mask         = out_ch.row_mask;
        got.fg_color         = out_ch.fg_color;
        got.bg_color         = out_ch.bg_color;
        got.paint_background = out_ch.paint_background;
        got.last             = out_ch.last;
        sb.check_scanline(got);
      end
      out_ch.ready <= (rst_n && $urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input item_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= rq.req_type;
    in_ch.character_code <= rq.character_code;
    in_ch.attribute      <= rq.attribute;
    in_ch.cell_column    <= rq.cell_column;
    in_ch.cell_row       <= rq.cell_row;
    in_ch.glyph_row      <= rq.glyph_row;
    in_ch.glyph_byte     <= rq.glyph_byte;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
    case (rq.req_type)
      REQ_FONT: begin
        n_font++;
        rows_written[rq.character_code][rq.glyph_row] = 1'b1;
      end
      REQ_CELL:   n_cell++;
      REQ_CURSOR: n_cursor++;
      default: ;
    endcase
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (sb.pending_scanlines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic item_t font_request(logic [7:0] ch, logic [3:0] row, logic [7:0] bits);
    item_t rq;
    rq                = item_t'($urandom);
    rq.req_type       = REQ_FONT;
    rq.character_code = ch;
    rq.glyph_row      = row;
    rq.glyph_byte     = bits;
    return rq;
  endfunction

  function automatic item_t draw_request(logic [1:0] kind, logic [7:0] ch, logic [7:0] attr,
                                         logic [15:0] col, logic [15:0] row);
    item_t rq;
    rq                = item_t'($urandom);
    rq.req_type       = kind;
    rq.character_code = ch;
    rq.attribute      = attr;
    rq.cell_column    = col;
    rq.cell_row       = row;
    return rq;
  endfunction

  function automatic logic [7:0] pick_ready_char();
    logic [7:0] ch;
    ch = 8'($urandom);
    while (rows_written[ch] != 16'hffff) ch++;
    return ch;
  endfunction

  function automatic logic [15:0] cursor_coord(logic [7:0] bound);
    case ($urandom_range(7))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'(bound) - 16'd1;
      3: return 16'(bound);
      4: return 16'(bound) + 16'd1;
      5: return 16'($urandom);
      default: return 16'($urandom_range(int'(bound) - 1));
    endcase
  endfunction

  task automatic run_directed();
    logic [7:0] pattern [GLYPH_ROWS];
    pattern = '{8'h00, 8'hff, 8'h80, 8'h01, 8'haa, 8'h55, 8'h18, 8'h3c,
                8'h7e, 8'hc3, 8'h0f, 8'hf0, 8'h66, 8'h99, 8'he7, 8'hff};
    for (int s = 0; s < GLYPH_ROWS; s++)
      send_request(font_request(8'hff, 4'(s), pattern[s]));
    send_request(draw_request(REQ_CELL, 8'hff, 8'h00, 16'h0000, 16'h0000));
    send_request(draw_request(REQ_CELL, 8'hff, 8'hff, 16'h8000, 16'h7fff));
    send_request(draw_request(REQ_CELL, 8'hff, 8'hd7, 16'h7fff, 16'h8000));
    send_request(draw_request(REQ_CURSOR, 8'h00, 8'h00, 16'd0, 16'd0));
    send_request(draw_request(REQ_CURSOR, 8'h00, 8'h00, 16'd79, 16'd24));
    send_request(draw_request(REQ_CURSOR, 8'h00, 8'h00, 16'd80, 16'd0));
    send_request(draw_request(REQ_CURSOR, 8'h00, 8'h00, 16'd0, 16'd25));
    send_request(draw_request(REQ_CURSOR, 8'h00, 8'h00, 16'hffff, 16'd3));
    send_request(draw_request(2'd3, 8'hff, 8'hff, 16'd1, 16'd1));
  endtask

  task automatic run_random(input int count);
    int sent;
    int pick;
    logic [7:0] ch;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        ch = 8'($urandom);
        for (int s = 0; s < GLYPH_ROWS; s++)
          send_request(font_request(ch, 4'(s), 8'($urandom)));
        sent += GLYPH_ROWS;
      end else if (pick < 15) begin
        send_request(font_request(8'($urandom), 4'($urandom), 8'($urandom)));
        sent++;
      end else if (pick < 27) begin
        send_request(font_request(pick_ready_char(), 4'($urandom), 8'($urandom)));
        sent++;
      end else if (pick < 75) begin
        send_request(draw_request(REQ_CELL, pick_ready_char(), 8'($urandom),
                                  16'($urandom), 16'($urandom)));
        sent++;
      end else if (pick < 95) begin
        send_request(draw_request(REQ_CURSOR, 8'($urandom), 8'($urandom),
                                  cursor_coord(sb.columns_limit), cursor_coord(sb.rows_limit)));
        sent++;
      end else begin
        send_request(draw_request(2'd3, 8'($urandom), 8'($urandom),
                                  16'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [7:0] col_setting [6];
    logic [7:0] row_setting [6];
    col_setting = '{8'd80, 8'd1, 8'd255, 8'd1, 8'd255, 8'd0};
    row_setting = '{8'd25, 8'd1, 8'd255, 8'd255, 8'd1, 8'd0};
    col_setting[5] = 8'($urandom_range(255, 1));
    row_setting[5] = 8'($urandom_range(255, 1));
    sb = new();
    foreach (rows_written[i]) rows_written[i] = 16'h0000;
    n_font   = 0;
    n_cell   = 0;
    n_cursor = 0;
    send_idle_pct = 20;
    recv_idle_pct = 77;
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_FONT;
    in_ch.character_code <= '0;
    in_ch.attribute      <= '0;
    in_ch.cell_column    <= '0;
    in_ch.cell_row       <= '0;
    in_ch.glyph_row      <= '0;
    in_ch.glyph_byte     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin send_idle_pct = 20; recv_idle_pct = 77; end
        1: begin send_idle_pct = 77; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_register(REG_COLUMNS, col_setting[phase]);
      write_register(REG_ROWS, row_setting[phase]);
      if (phase == 0) run_directed();
      run_random(ITEMS_PER_PHASE);
      settle_block();
    end
    $display("Covered %0d font writes, %0d cells and %0d cursor requests (%0d shown).",
             n_font, n_cell, n_cursor, sb.cursors_shown);
    $display("Checked %0d scanlines over six bound settings and three stall patterns.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("** text_mode_glyph_renderer: PASSED **");
    end else begin
      $display("** text_mode_glyph_renderer: FAILED **");
    end
    $finish;
  end

endmodule

/* text_mode_glyph_renderer.f */
sv/tmgr_pkg.sv
sv/tmgr_in_if.sv
sv/tmgr_out_if.sv
sv/tmgr_ram.sv
sv/tmgr_ctrl.sv
sv/tmgr_dp.sv
sv/text_mode_glyph_renderer.sv
tb/tb_text_mode_glyph_renderer.sv
